// ===== hdl/clbs_pkg.sv =====
package clbs_pkg;

  // Request kinds
  localparam logic [2:0] ACT_INIT  = 3'd0;
  localparam logic [2:0] ACT_CMD   = 3'd1;
  localparam logic [2:0] ACT_DATA  = 3'd2;
  localparam logic [2:0] ACT_POS   = 3'd3;
  localparam logic [2:0] ACT_GLYPH = 3'd4;

  // Byte slot counter, up to eleven bytes per request
  localparam int unsigned ByteIdxW = 4;

  // Wait field
  localparam int unsigned WaitW = 15;
  localparam logic [WaitW-1:0] WAIT_POWER_US = 15'd20000;
  localparam logic [WaitW-1:0] WAIT_FSET2_US = 15'd5000;
  localparam logic [WaitW-1:0] WAIT_FSET3_US = 15'd150;
  localparam logic [WaitW-1:0] WAIT_NONE     = 15'd0;

  // Register select
  localparam logic RS_CMD  = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Controller command to the datapath
  typedef struct packed {
    logic                load_req;
    logic                load_out;
    logic [ByteIdxW-1:0] byte_idx;
    logic                nibble;
  } clbs_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic byte_skip;
    logic byte_last;
    logic four_bit;
  } clbs_sts_t;

  // DDRAM base address of rows one to four
  function automatic logic [7:0] row_base(input logic [1:0] idx);
    logic [7:0] base;
    unique case (idx)
      2'd0:    base = 8'h00;
      2'd1:    base = 8'h40;
      2'd2:    base = 8'h14;
      default: base = 8'h54;
    endcase
    return base;
  endfunction

endpackage

// ===== hdl/clbs_ctrl.sv =====
module clbs_ctrl
  import clbs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  clbs_sts_t sts_i,
  output clbs_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                state_q, state_d;
  logic [ByteIdxW-1:0] idx_q, idx_d;
  logic                nib_q, nib_d;
  logic                oval_q, oval_d;
  logic                in_acc, out_free, strobe_last, load_out;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !oval_q || !out_stall_i;
  assign strobe_last = sts_i.byte_last && (!sts_i.four_bit || nib_q);

  // Step through the byte slots, one strobe per free output slot
  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    nib_d    = nib_q;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_RUN;
          idx_d   = '0;
          nib_d   = 1'b0;
        end
      end
      default: begin
        if (sts_i.byte_skip) begin
          if (sts_i.byte_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else if (out_free) begin
          load_out = 1'b1;
          if (sts_i.four_bit && !nib_q) begin
            nib_d = 1'b1;
          end else begin
            nib_d = 1'b0;
            idx_d = idx_q + 1'b1;
          end
          if (strobe_last) begin
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  // Output register occupancy
  always_comb begin
    oval_d = oval_q;
    if (load_out) begin
      oval_d = 1'b1;
    end else if (!out_stall_i) begin
      oval_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      nib_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      nib_q   <= nib_d;
      oval_q  <= oval_d;
    end
  end

  assign out_valid_o    = oval_q;
  assign cmd_o.load_req = in_acc;
  assign cmd_o.load_out = load_out;
  assign cmd_o.byte_idx = idx_q;
  assign cmd_o.nibble   = nib_q;

endmodule

// ===== hdl/clbs_datapath.sv =====
module clbs_datapath
  import clbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic [2:0]       action_i,
  input  logic [7:0]       byte_value_i,
  input  logic [7:0]       row_i,
  input  logic [7:0]       column_i,
  input  logic [63:0]      glyph_rows_i,
  input  logic [2:0]       glyph_slot_i,
  input  clbs_cmd_t        cmd_i,
  output clbs_sts_t        sts_o,
  output logic             reg_select_o,
  output logic [7:0]       bus_value_o,
  output logic [WaitW-1:0] wait_before_us_o,
  output logic             last_o
);

  logic             four_q;
  logic [2:0]       action_q;
  logic [7:0]       byte_q, row_q, column_q;
  logic [63:0]      glyph_q;
  logic [2:0]       slot_q;
  logic             rs_q;
  logic [7:0]       bus_q;
  logic [WaitW-1:0] wait_q;
  logic             last_q;

  logic             b_rs, b_skip, b_last;
  logic [7:0]       b_val, addr_cmd, glyph_byte;
  logic [WaitW-1:0] b_wait;
  logic             row_ok;
  logic [1:0]       row_idx;
  logic [2:0]       glyph_sel;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      four_q <= 1'b0;
    end else if (cfg_we_i) begin
      four_q <= cfg_wdata_i;
    end
  end

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      action_q <= action_i;
      byte_q   <= byte_value_i;
      row_q    <= row_i;
      column_q <= column_i;
      glyph_q  <= glyph_rows_i;
      slot_q   <= glyph_slot_i;
    end
  end

  // DDRAM address command and glyph row select (slots 1 to 8 give rows 0 to 7)
  assign row_ok     = (row_q >= 8'd1) && (row_q <= 8'd4);
  assign row_idx    = row_q[1:0] - 2'd1;
  assign addr_cmd   = 8'h80 + row_base(row_idx) + (column_q - 8'd1);
  assign glyph_sel  = cmd_i.byte_idx[2:0] - 3'd1;
  assign glyph_byte = glyph_q[8*glyph_sel +: 8];

  // Byte at the current slot of the request
  always_comb begin
    b_rs   = RS_CMD;
    b_val  = 8'h00;
    b_wait = WAIT_NONE;
    b_skip = 1'b0;
    b_last = 1'b0;
    unique case (action_q)
      ACT_INIT: begin
        unique case (cmd_i.byte_idx)
          4'd0: begin
            b_val  = 8'h30;
            b_wait = WAIT_POWER_US;
          end
          4'd1: begin
            b_val  = 8'h30;
            b_wait = WAIT_FSET2_US;
          end
          4'd2: begin
            b_val  = 8'h30;
            b_wait = WAIT_FSET3_US;
          end
          4'd3: begin
            b_val  = 8'h02;
            b_skip = !four_q;
          end
          4'd4: b_val = four_q ? 8'h28 : 8'h38;
          4'd5: b_val = 8'h0C;
          4'd6: b_val = 8'h01;
          4'd7: b_val = 8'h06;
          4'd8: begin
            b_val  = 8'h02;
            b_last = 1'b1;
          end
          default: begin
            b_skip = 1'b1;
            b_last = 1'b1;
          end
        endcase
      end
      ACT_CMD: begin
        b_val  = byte_q;
        b_last = 1'b1;
      end
      ACT_DATA: begin
        b_rs   = RS_DATA;
        b_val  = byte_q;
        b_last = 1'b1;
      end
      ACT_POS: begin
        if (cmd_i.byte_idx == 4'd0) begin
          b_val  = addr_cmd;
          b_skip = !row_ok;
        end else begin
          b_rs   = RS_DATA;
          b_val  = byte_q;
          b_last = 1'b1;
        end
      end
      ACT_GLYPH: begin
        priority if (cmd_i.byte_idx == 4'd0) begin
          b_val = {2'b01, slot_q, 3'b000};
        end else if (cmd_i.byte_idx <= 4'd8) begin
          b_rs  = RS_DATA;
          b_val = glyph_byte;
        end else if (cmd_i.byte_idx == 4'd9) begin
          b_val  = addr_cmd;
          b_skip = !row_ok;
        end else begin
          b_rs   = RS_DATA;
          b_val  = {5'b00000, slot_q};
          b_last = 1'b1;
        end
      end
      default: begin
        // unused request codes produce nothing
        b_skip = 1'b1;
        b_last = 1'b1;
      end
    endcase
  end

  // Output register, one strobe per transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rs_q   <= b_rs;
      last_q <= b_last && (!four_q || cmd_i.nibble);
      if (four_q) begin
        bus_q <= cmd_i.nibble ? {4'h0, b_val[3:0]} : {4'h0, b_val[7:4]};
      end else begin
        bus_q <= b_val;
      end
      wait_q <= cmd_i.nibble ? WAIT_NONE : b_wait;
    end
  end

  assign sts_o.byte_skip = b_skip;
  assign sts_o.byte_last = b_last;
  assign sts_o.four_bit  = four_q;

  assign reg_select_o     = rs_q;
  assign bus_value_o      = bus_q;
  assign wait_before_us_o = wait_q;
  assign last_o           = last_q;

endmodule

// ===== hdl/char_lcd_bus_sequencer_top.sv =====
// Character LCD bus sequencer. Each accepted request is expanded into a run of
// enable strobes (register select, bus value, wait before the strobe, last
// flag), one output transfer per strobe. After the request is taken, the sequencer
// emits one strobe per cycle while the output side keeps up, and it passes over
// each byte slot that is dropped without a strobe (the 0x02 byte of init in 8-bit
// mode, the address command for a bad row). Strobes leave through a single output
// register; a new request is taken once the previous one's last strobe is in it.
module char_lcd_bus_sequencer_top
  import clbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       action_i,
  input  logic [7:0]       byte_value_i,
  input  logic [7:0]       row_i,
  input  logic [7:0]       column_i,
  input  logic [63:0]      glyph_rows_i,
  input  logic [2:0]       glyph_slot_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             reg_select_o,
  output logic [7:0]       bus_value_o,
  output logic [WaitW-1:0] wait_before_us_o,
  output logic             last_o
);

  clbs_cmd_t cmd;
  clbs_sts_t sts;

  clbs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  clbs_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .action_i         (action_i),
    .byte_value_i     (byte_value_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .glyph_rows_i     (glyph_rows_i),
    .glyph_slot_i     (glyph_slot_i),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .reg_select_o     (reg_select_o),
    .bus_value_o      (bus_value_o),
    .wait_before_us_o (wait_before_us_o),
    .last_o           (last_o)
  );

  // A taken request keeps the input side busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken but sequencer not busy");

  // Only init command strobes carry a wait, never the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (wait_before_us_o != WAIT_NONE) |-> (reg_select_o == RS_CMD) && !last_o)
    else $error("wait on a data or final strobe");

  // Start-up waits come from the fixed set only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wait_before_us_o == WAIT_NONE) || (wait_before_us_o == WAIT_POWER_US)
                    || (wait_before_us_o == WAIT_FSET2_US) || (wait_before_us_o == WAIT_FSET3_US))
    else $error("unexpected wait value");

endmodule

// ===== tb/tb_char_lcd_bus_sequencer_top.sv =====
`timescale 1ns / 100ps

module tb_char_lcd_bus_sequencer_top;
  import clbs_pkg::*;

  // HD44780 command codes
  localparam logic [7:0] CMD_FSET_8     = 8'h30;
  localparam logic [7:0] CMD_FSET_4     = 8'h20;
  localparam logic [7:0] CMD_TWO_ROWS   = 8'h08;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY_INC  = 8'h06;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_DDRAM      = 8'h80;
  localparam logic [7:0] CMD_CGRAM      = 8'h40;

  // Action codes the block ignores
  localparam logic [2:0] ACT_SPARE_5 = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam logic BUS_8BIT = 1'b0;
  localparam logic BUS_4BIT = 1'b1;

  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned NUM_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS   = 50;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_REPORTS   = 40;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_val;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [63:0] glyph_rows;
    logic [2:0]  glyph_slot;
  } lcd_req_t;

  typedef struct packed {
    logic             rs;
    logic [7:0]       bus;
    logic [WaitW-1:0] wait_us;
    logic             last;
  } lcd_strobe_t;

  typedef enum logic [1:0] {CHECK_PREDICTED, CHECK_ONE_STROBE, CHECK_SILENT} check_kind_e;

  typedef struct {
    logic        mode;
    lcd_req_t    req;
    check_kind_e kind;
    lcd_strobe_t strobe;
  } stim_row_t;

  localparam lcd_strobe_t NO_STROBE = '0;

  // Clock, reset and block ports
  logic             clk_i;
  logic             rst_ni           = 1'b0;
  logic             cfg_we_i         = 1'b0;
  logic             cfg_wdata_i      = 1'b0;
  logic             in_valid_i       = 1'b0;
  logic             in_stall_o;
  logic [2:0]       action_i         = '0;
  logic [7:0]       byte_value_i     = '0;
  logic [7:0]       row_i            = '0;
  logic [7:0]       column_i         = '0;
  logic [63:0]      glyph_rows_i     = '0;
  logic [2:0]       glyph_slot_i     = '0;
  logic             out_valid_o;
  logic             out_stall_i      = 1'b0;
  logic             reg_select_o;
  logic [7:0]       bus_value_o;
  logic [WaitW-1:0] wait_before_us_o;
  logic             last_o;

  // Shadow of the bus width register and the strobes still owed by the block
  logic          lcd_four_bit = BUS_8BIT;
  lcd_strobe_t   strobe_q[$];
  stim_row_t     stim_rows[$];

  int unsigned   mismatch_count = 0;
  int unsigned   strobes_seen   = 0;
  int unsigned   requests_sent  = 0;
  int unsigned   ignored_sent   = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   hold_left      = 0;
  int unsigned   stall_left     = 0;
  bit            calm           = 1'b0;
  bit            hold_req       = 1'b0;
  bit            saw_8bit       = 1'b0;
  bit            saw_4bit       = 1'b0;

  char_lcd_bus_sequencer_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .byte_value_i     (byte_value_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .glyph_rows_i     (glyph_rows_i),
    .glyph_slot_i     (glyph_slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .reg_select_o     (reg_select_o),
    .bus_value_o      (bus_value_o),
    .wait_before_us_o (wait_before_us_o),
    .last_o           (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // One byte on the bus: a single strobe, or two nibbles high first
  function automatic void owe_byte(input logic rs, input logic [7:0] val,
                                   input logic [WaitW-1:0] wait_us);
    if (lcd_four_bit) begin
      strobe_q.push_back('{rs, {4'h0, val[7:4]}, wait_us, 1'b0});
      strobe_q.push_back('{rs, {4'h0, val[3:0]}, WAIT_NONE, 1'b0});
    end else begin
      strobe_q.push_back('{rs, val, wait_us, 1'b0});
    end
  endfunction

  // DDRAM address for rows one to four, then the character itself
  function automatic void owe_placed_char(input logic [7:0] row, input logic [7:0] column,
                                          input logic [7:0] val);
    logic [7:0] base;
    logic [7:0] addr;
    if (row >= 8'd1 && row <= 8'd4) begin
      case (row)
        8'd1:    base = 8'h00;
        8'd2:    base = 8'h40;
        8'd3:    base = 8'h14;
        default: base = 8'h54;
      endcase
      addr = CMD_DDRAM + base + (column - 8'd1);
      owe_byte(RS_CMD, addr, WAIT_NONE);
    end
    owe_byte(RS_DATA, val, WAIT_NONE);
  endfunction

  // Expands one accepted request into the strobes the block must produce
  function automatic void expand_request(input lcd_req_t r);
    int unsigned  first;
    lcd_strobe_t  tail;
    first = strobe_q.size();
    case (r.action)
      ACT_INIT: begin
        owe_byte(RS_CMD, CMD_FSET_8, WAIT_POWER_US);
        owe_byte(RS_CMD, CMD_FSET_8, WAIT_FSET2_US);
        owe_byte(RS_CMD, CMD_FSET_8, WAIT_FSET3_US);
        if (lcd_four_bit) begin
          owe_byte(RS_CMD, CMD_FSET_4 >> 4, WAIT_NONE);
          owe_byte(RS_CMD, CMD_FSET_4 | CMD_TWO_ROWS, WAIT_NONE);
        end else begin
          owe_byte(RS_CMD, CMD_FSET_8 | CMD_TWO_ROWS, WAIT_NONE);
        end
        owe_byte(RS_CMD, CMD_DISPLAY_ON, WAIT_NONE);
        owe_byte(RS_CMD, CMD_CLEAR, WAIT_NONE);
        owe_byte(RS_CMD, CMD_ENTRY_INC, WAIT_NONE);
        owe_byte(RS_CMD, CMD_HOME, WAIT_NONE);
      end
      ACT_CMD:  owe_byte(RS_CMD, r.byte_val, WAIT_NONE);
      ACT_DATA: owe_byte(RS_DATA, r.byte_val, WAIT_NONE);
      ACT_POS:  owe_placed_char(r.row, r.column, r.byte_val);
      ACT_GLYPH: begin
        owe_byte(RS_CMD, CMD_CGRAM + {2'b00, r.glyph_slot, 3'b000}, WAIT_NONE);
        for (int i = 0; i < 8; i++) owe_byte(RS_DATA, r.glyph_rows[8*i +: 8], WAIT_NONE);
        owe_placed_char(r.row, r.column, {5'b0, r.glyph_slot});
      end
      default: ;
    endcase
    // flag the final strobe of the request
    if (strobe_q.size() > first) begin
      tail      = strobe_q.pop_back();
      tail.last = 1'b1;
      strobe_q.push_back(tail);
    end
  endfunction

  // Offers one request and returns at the edge where the transfer happens
  task automatic send_request(input lcd_req_t r);
    in_valid_i   <= 1'b1;
    action_i     <= r.action;
    byte_value_i <= r.byte_val;
    row_i        <= r.row;
    column_i     <= r.column;
    glyph_rows_i <= r.glyph_rows;
    glyph_slot_i <= r.glyph_slot;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (lcd_four_bit) saw_4bit = 1'b1;
    else saw_8bit = 1'b1;
  endtask

  task automatic sender_gap();
    int unsigned n;
    if (!calm && $urandom_range(0, 2) == 0) begin
      n = pick_gap();
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Waits until every owed strobe is out, then lets ignored requests settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (strobe_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_bus_width(input logic four_bit);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= four_bit;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    lcd_four_bit = four_bit;
  endtask

  task automatic add_row(input logic m, input logic [2:0] act, input logic [7:0] bv,
                         input logic [7:0] r, input logic [7:0] c, input logic [63:0] g,
                         input logic [2:0] s, input check_kind_e k, input lcd_strobe_t t);
    stim_row_t e;
    e.mode   = m;
    e.req    = '{act, bv, r, c, g, s};
    e.kind   = k;
    e.strobe = t;
    stim_rows.push_back(e);
  endtask

  function automatic lcd_req_t random_request();
    lcd_req_t    r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      r.action = ACT_INIT;
    else if (pick < 30) r.action = ACT_CMD;
    else if (pick < 50) r.action = ACT_DATA;
    else if (pick < 75) r.action = ACT_POS;
    else if (pick < 95) r.action = ACT_GLYPH;
    else                r.action = ACT_SPARE_5 + 3'($urandom_range(0, 2));
    r.byte_val   = 8'($urandom_range(0, 255));
    r.row        = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 4))
                                               : 8'($urandom_range(0, 255));
    r.column     = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 40))
                                              : 8'($urandom_range(0, 255));
    r.glyph_rows = {$urandom(), $urandom()};
    r.glyph_slot = 3'($urandom_range(0, 7));
    return r;
  endfunction

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Output side: check each strobe transfer, then pick the next stall value
  initial begin
    lcd_strobe_t exp_s;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        strobes_seen++;
        if (strobe_q.size() == 0) begin
          log_mismatch($sformatf("unexpected strobe rs=%0b bus=%02h", reg_select_o,
                                 bus_value_o));
        end else begin
          exp_s = strobe_q.pop_front();
          if (reg_select_o !== exp_s.rs)
            log_mismatch($sformatf("reg_select %0b, want %0b", reg_select_o, exp_s.rs));
          if (bus_value_o !== exp_s.bus)
            log_mismatch($sformatf("bus_value %02h, want %02h", bus_value_o, exp_s.bus));
          if (wait_before_us_o !== exp_s.wait_us)
            log_mismatch($sformatf("wait_before_us %0d, want %0d", wait_before_us_o,
                                   exp_s.wait_us));
          if (last_o !== exp_s.last)
            log_mismatch($sformatf("last %0b, want %0b", last_o, exp_s.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_req) begin
        hold_req    = 1'b0;
        hold_left   = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Stimulus
  initial begin
    lcd_req_t    req;
    stim_row_t   e;
    int unsigned served;

    // 8-bit bus straight out of reset
    add_row(BUS_8BIT, ACT_INIT, 8'h00, 8'd0, 8'd0, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_8BIT, ACT_CMD, 8'h00, 8'd0, 8'd0, 64'h0, 3'd0, CHECK_ONE_STROBE,
            '{RS_CMD, 8'h00, WAIT_NONE, 1'b1});
    add_row(BUS_8BIT, ACT_CMD, 8'hFF, 8'hFF, 8'hFF, '1, 3'd7, CHECK_ONE_STROBE,
            '{RS_CMD, 8'hFF, WAIT_NONE, 1'b1});
    add_row(BUS_8BIT, ACT_DATA, 8'h00, 8'd0, 8'd0, 64'h0, 3'd0, CHECK_ONE_STROBE,
            '{RS_DATA, 8'h00, WAIT_NONE, 1'b1});
    add_row(BUS_8BIT, ACT_DATA, 8'hFF, 8'hFF, 8'hFF, '1, 3'd7, CHECK_ONE_STROBE,
            '{RS_DATA, 8'hFF, WAIT_NONE, 1'b1});
    add_row(BUS_8BIT, ACT_POS, 8'h41, 8'd1, 8'd1, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_8BIT, ACT_POS, 8'h5A, 8'd4, 8'd255, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    // rows outside one to four: no address command
    add_row(BUS_8BIT, ACT_POS, 8'h33, 8'd0, 8'd5, 64'h0, 3'd0, CHECK_ONE_STROBE,
            '{RS_DATA, 8'h33, WAIT_NONE, 1'b1});
    add_row(BUS_8BIT, ACT_POS, 8'h7E, 8'd255, 8'd0, 64'h0, 3'd0, CHECK_ONE_STROBE,
            '{RS_DATA, 8'h7E, WAIT_NONE, 1'b1});
    // column zero wraps before the add
    add_row(BUS_8BIT, ACT_POS, 8'h21, 8'd2, 8'd0, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_8BIT, ACT_GLYPH, 8'h00, 8'd3, 8'd20, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_8BIT, ACT_GLYPH, 8'h00, 8'd5, 8'd1, '1, 3'd7, CHECK_PREDICTED, NO_STROBE);
    // spare action codes produce nothing
    add_row(BUS_8BIT, ACT_SPARE_5, 8'h12, 8'd1, 8'd1, 64'h0, 3'd0, CHECK_SILENT, NO_STROBE);
    add_row(BUS_8BIT, ACT_SPARE_7, 8'hFF, 8'hFF, 8'hFF, '1, 3'd7, CHECK_SILENT, NO_STROBE);
    // 4-bit bus
    add_row(BUS_4BIT, ACT_INIT, 8'h00, 8'd0, 8'd0, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_CMD, 8'hA5, 8'd0, 8'd0, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_DATA, 8'h5A, 8'd0, 8'd0, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_POS, 8'hC3, 8'd3, 8'd40, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_POS, 8'h3C, 8'd9, 8'd1, 64'h0, 3'd0, CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_GLYPH, 8'h00, 8'd1, 8'd16, 64'h0011_2233_4455_6677, 3'd5,
            CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_GLYPH, 8'h00, 8'd0, 8'd0, 64'hF0E1_D2C3_B4A5_9687, 3'd2,
            CHECK_PREDICTED, NO_STROBE);
    add_row(BUS_4BIT, ACT_SPARE_6, 8'h00, 8'd2, 8'd2, 64'h0, 3'd1, CHECK_SILENT, NO_STROBE);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (stim_rows[i]) begin
      e = stim_rows[i];
      if (e.mode != lcd_four_bit) begin
        drain();
        set_bus_width(e.mode);
      end
      send_request(e.req);
      case (e.kind)
        CHECK_ONE_STROBE: strobe_q.push_back(e.strobe);
        CHECK_PREDICTED:  expand_request(e.req);
        default: ;
      endcase
      if (e.req.action > ACT_GLYPH) ignored_sent++;
      else requests_sent++;
      sender_gap();
    end

    // Random phases: bus width per phase, one phase without idling,
    // one with a long receiver hold-off while requests keep coming
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      if (ph == 0)      set_bus_width(BUS_4BIT);
      else if (ph == 1) set_bus_width(BUS_8BIT);
      else              set_bus_width(1'($urandom_range(0, 1)));
      calm = (ph == 2);
      if (ph == 3) hold_req = 1'b1;
      served = 0;
      while (served < PHASE_ITEMS) begin
        req = random_request();
        send_request(req);
        expand_request(req);
        if (req.action > ACT_GLYPH) ignored_sent++;
        else begin
          requests_sent++;
          served++;
        end
        sender_gap();
      end
    end
    calm = 1'b0;
    drain();

    $display("Run covered %0d requests and %0d spare codes over %0d cycles.",
             requests_sent, ignored_sent, cycle_count);
    $display("%0d strobes checked, 8-bit bus %0s, 4-bit bus %0s, %0d mismatches.",
             strobes_seen, saw_8bit ? "used" : "unused", saw_4bit ? "used" : "unused",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
